// ----- hdl/mmsc_pkg.sv -----
// Shared types and constants for the memory map segment coalescer.
package mmsc_pkg;

  localparam int unsigned MaxSegmentsDef = 32;
  localparam int unsigned PageShift      = 12;
  localparam int unsigned AttrWbBit      = 3;
  localparam int unsigned SegIndexW      = 5;

  localparam int unsigned InTdataW  = 216;
  localparam int unsigned InTuserW  = 1;
  localparam int unsigned OutTdataW = 136;
  localparam int unsigned OutTuserW = 3;

  // UEFI memory types that the classifier maps explicitly
  localparam logic [31:0] MT_LOADER_CODE  = 32'd1;
  localparam logic [31:0] MT_LOADER_DATA  = 32'd2;
  localparam logic [31:0] MT_BS_CODE      = 32'd3;
  localparam logic [31:0] MT_BS_DATA      = 32'd4;
  localparam logic [31:0] MT_CONVENTIONAL = 32'd7;
  localparam logic [31:0] MT_ACPI_RECLAIM = 32'd9;
  localparam logic [31:0] MT_ACPI_NVS     = 32'd10;
  localparam logic [31:0] MT_PERSISTENT   = 32'd14;

  typedef enum logic [2:0] {
    CLS_MEMORY   = 3'd0,
    CLS_RESERVED = 3'd1,
    CLS_ACPI     = 3'd2,
    CLS_NVS      = 3'd3,
    CLS_PMEM     = 3'd4
  } seg_class_e;

  typedef enum logic {
    KIND_DESC   = 1'b0,
    KIND_FINISH = 1'b1
  } item_kind_e;

  typedef struct packed {
    item_kind_e  kind;
    logic [63:0] addr;
    logic [51:0] pages;
    logic [31:0] mem_type;
    logic        write_back;
  } in_beat_t;

endpackage

// ----- hdl/mmsc_classify.sv -----
// Maps a UEFI memory type and write-back attribute onto an E820-style class.
module mmsc_classify (
  input  logic [31:0]             mem_type_i,
  input  logic                    write_back_i,
  output mmsc_pkg::seg_class_e    cls_o
);

  always_comb begin
    case (mem_type_i)
      mmsc_pkg::MT_LOADER_CODE,
      mmsc_pkg::MT_LOADER_DATA,
      mmsc_pkg::MT_BS_CODE,
      mmsc_pkg::MT_BS_DATA,
      mmsc_pkg::MT_CONVENTIONAL: begin
        cls_o = write_back_i ? mmsc_pkg::CLS_MEMORY : mmsc_pkg::CLS_RESERVED;
      end
      mmsc_pkg::MT_ACPI_RECLAIM: cls_o = mmsc_pkg::CLS_ACPI;
      mmsc_pkg::MT_ACPI_NVS:     cls_o = mmsc_pkg::CLS_NVS;
      mmsc_pkg::MT_PERSISTENT:   cls_o = mmsc_pkg::CLS_PMEM;
      default:                   cls_o = mmsc_pkg::CLS_RESERVED;
    endcase
  end

endmodule

// ----- hdl/memory_map_segment_coalescer_core.sv -----
// Coalesces UEFI memory descriptors into E820-style segments; top level.
//
// Descriptor beats enter on s_axis, one per cycle sustained while no result
// beat is held on m_axis; a beat that produces a result waits while m_axis
// holds one that is not taken. Each beat is registered, then classified and
// compared against the pending segment combinationally, and the result beat
// is registered before it is presented on m_axis. The cycle is set by the
// 64-bit end-address add and the 64-bit contiguity compare. A descriptor
// that continues the pending segment with the same class produces no beat;
// a break emits the pending segment. Once MaxSegments segments are out,
// descriptors are dropped until a finish beat (tuser = 1), which always answers
// with one beat (the last segment, the overflow flag or neither) and clears all state.
module memory_map_segment_coalescer_core #(
  parameter int unsigned MaxSegments = mmsc_pkg::MaxSegmentsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [63:0] phys_addr, [115:64] page_count, [147:116] mem_type,
  // [211:148] attributes, [215:212] zero
  input  logic [mmsc_pkg::InTdataW-1:0]  s_axis_tdata,
  // [0] kind
  input  logic [mmsc_pkg::InTuserW-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [63:0] seg_addr, [127:64] seg_size, [130:128] seg_class, [135:131] seg_index
  output logic [mmsc_pkg::OutTdataW-1:0] m_axis_tdata,
  // [0] seg_valid, [1] final_res, [2] overflow
  output logic [mmsc_pkg::OutTuserW-1:0] m_axis_tuser
);

  localparam int unsigned CntW = $clog2(MaxSegments + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxSegments);

  // input register
  logic               in_vld_q;
  mmsc_pkg::in_beat_t in_q;
  logic               fire;

  // coalescing state
  logic [63:0]          pend_start_q, pend_start_d;
  logic [63:0]          pend_end_q, pend_end_d;
  logic [63:0]          pend_size_q, pend_size_d;
  mmsc_pkg::seg_class_e pend_cls_q, pend_cls_d;
  logic                 have_pend_q, have_pend_d;
  logic [CntW-1:0]      seg_cnt_q, seg_cnt_d;
  logic                 limit_hit_q, limit_hit_d;

  // result register
  logic                 out_vld_q;
  logic                 res_seg_vld_q, res_fin_q, res_ovf_q;
  logic [63:0]          res_addr_q, res_size_q;
  mmsc_pkg::seg_class_e res_cls_q;
  logic [mmsc_pkg::SegIndexW-1:0] res_idx_q;

  // step outputs
  logic                 has_res;
  logic                 r_seg_vld, r_fin, r_ovf;
  logic [63:0]          r_addr, r_size;
  mmsc_pkg::seg_class_e r_cls;
  logic [mmsc_pkg::SegIndexW-1:0] r_idx;

  mmsc_pkg::seg_class_e cls;
  logic [63:0]          desc_size, desc_end;
  logic                 contiguous;
  logic [CntW-1:0]      cnt_inc;
  logic [CntW+mmsc_pkg::SegIndexW-1:0] cnt_ext;
  logic                 out_free;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && (!has_res || out_free);
  assign s_axis_tready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.kind       <= mmsc_pkg::item_kind_e'(s_axis_tuser[0]);
      in_q.addr       <= s_axis_tdata[63:0];
      in_q.pages      <= s_axis_tdata[115:64];
      in_q.mem_type   <= s_axis_tdata[147:116];
      in_q.write_back <= s_axis_tdata[148 + mmsc_pkg::AttrWbBit];
    end
  end

  mmsc_classify u_classify (
    .mem_type_i   (in_q.mem_type),
    .write_back_i (in_q.write_back),
    .cls_o        (cls)
  );

  assign desc_size  = {in_q.pages, {mmsc_pkg::PageShift{1'b0}}};
  assign desc_end   = in_q.addr + desc_size;
  assign contiguous = (pend_cls_q == cls) && (pend_end_q == in_q.addr);
  assign cnt_inc    = seg_cnt_q + 1'b1;
  assign cnt_ext    = {{mmsc_pkg::SegIndexW{1'b0}}, seg_cnt_q};

  always_comb begin
    pend_start_d = pend_start_q;
    pend_end_d   = pend_end_q;
    pend_size_d  = pend_size_q;
    pend_cls_d   = pend_cls_q;
    have_pend_d  = have_pend_q;
    seg_cnt_d    = seg_cnt_q;
    limit_hit_d  = limit_hit_q;
    has_res      = 1'b0;
    r_seg_vld    = 1'b0;
    r_fin        = 1'b0;
    r_ovf        = 1'b0;
    r_addr       = '0;
    r_size       = '0;
    r_cls        = mmsc_pkg::CLS_MEMORY;
    r_idx        = '0;
    if (in_q.kind == mmsc_pkg::KIND_FINISH) begin
      has_res = 1'b1;
      r_fin   = 1'b1;
      if (have_pend_q && !limit_hit_q && (seg_cnt_q < MaxCnt)) begin
        r_seg_vld = 1'b1;
        r_addr    = pend_start_q;
        r_size    = pend_size_q;
        r_cls     = pend_cls_q;
        r_idx     = cnt_ext[mmsc_pkg::SegIndexW-1:0];
      end else if (limit_hit_q) begin
        r_ovf = 1'b1;
      end
      pend_start_d = '0;
      pend_end_d   = '0;
      pend_size_d  = '0;
      pend_cls_d   = mmsc_pkg::CLS_MEMORY;
      have_pend_d  = 1'b0;
      seg_cnt_d    = '0;
      limit_hit_d  = 1'b0;
    end else if (!limit_hit_q) begin
      if (have_pend_q && contiguous) begin
        pend_end_d  = desc_end;
        pend_size_d = pend_size_q + desc_size;
      end else begin
        if (have_pend_q) begin
          has_res   = 1'b1;
          r_seg_vld = 1'b1;
          r_addr    = pend_start_q;
          r_size    = pend_size_q;
          r_cls     = pend_cls_q;
          r_idx     = cnt_ext[mmsc_pkg::SegIndexW-1:0];
          seg_cnt_d = cnt_inc;
        end
        if (have_pend_q && (cnt_inc >= MaxCnt)) begin
          // table full: this descriptor is dropped with the rest
          limit_hit_d = 1'b1;
          have_pend_d = 1'b0;
        end else begin
          pend_start_d = in_q.addr;
          pend_end_d   = desc_end;
          pend_size_d  = desc_size;
          pend_cls_d   = cls;
          have_pend_d  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_start_q <= '0;
      pend_end_q   <= '0;
      pend_size_q  <= '0;
      pend_cls_q   <= mmsc_pkg::CLS_MEMORY;
      have_pend_q  <= 1'b0;
      seg_cnt_q    <= '0;
      limit_hit_q  <= 1'b0;
    end else if (fire) begin
      pend_start_q <= pend_start_d;
      pend_end_q   <= pend_end_d;
      pend_size_q  <= pend_size_d;
      pend_cls_q   <= pend_cls_d;
      have_pend_q  <= have_pend_d;
      seg_cnt_q    <= seg_cnt_d;
      limit_hit_q  <= limit_hit_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire && has_res) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && has_res) begin
      res_seg_vld_q <= r_seg_vld;
      res_fin_q     <= r_fin;
      res_ovf_q     <= r_ovf;
      res_addr_q    <= r_addr;
      res_size_q    <= r_size;
      res_cls_q     <= r_cls;
      res_idx_q     <= r_idx;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {res_idx_q, res_cls_q, res_size_q, res_addr_q};
  assign m_axis_tuser  = {res_ovf_q, res_fin_q, res_seg_vld_q};

  a_limit_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    limit_hit_q |-> !have_pend_q)
    else $error("pending segment held after segment limit");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_cnt_q <= MaxCnt)
    else $error("segment count beyond limit");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (in_q.kind == mmsc_pkg::KIND_FINISH))
      |=> (seg_cnt_q == '0) && !have_pend_q && !limit_hit_q)
    else $error("finish beat did not clear coalescing state");

  a_ovf_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_ovf_q) |-> (res_fin_q && !res_seg_vld_q))
    else $error("overflow flag on a non-final or segment-carrying beat");

  a_empty_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_seg_vld_q)
      |-> (res_addr_q == '0) && (res_size_q == '0) && (res_idx_q == '0))
    else $error("segment fields not zero on an empty result beat");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the memory map segment coalescer core.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned MaxSeg = mmsc_pkg::MaxSegmentsDef;
  localparam int HoldA = 300;
  localparam int HoldB = 620;

  typedef struct {
    mmsc_pkg::item_kind_e kind;
    logic [63:0]          addr;
    logic [51:0]          pages;
    logic [31:0]          mem_type;
    logic [63:0]          attr;
  } desc_item_t;

  typedef struct {
    logic                 seg_valid;
    logic [63:0]          addr;
    logic [63:0]          size;
    mmsc_pkg::seg_class_e cls;
    logic [4:0]           index;
    logic                 final_res;
    logic                 overflow;
  } seg_result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [mmsc_pkg::InTdataW-1:0]   s_axis_tdata = '0;
  logic [mmsc_pkg::InTuserW-1:0]   s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [mmsc_pkg::OutTdataW-1:0]  m_axis_tdata;
  logic [mmsc_pkg::OutTuserW-1:0]  m_axis_tuser;

  desc_item_t  desc_q[$];
  desc_item_t  cur_desc;
  seg_result_t seg_expect_q[$];
  int          n_accepted = 0;
  int          n_total = 1;
  int          n_errors = 0;

  // coalescing state mirrored from the block
  logic [63:0]          pend_start, pend_end;
  mmsc_pkg::seg_class_e pend_class;
  bit                   pend_valid;
  int                   seg_count;
  bit                   limit_hit;

  memory_map_segment_coalescer_core #(
    .MaxSegments(MaxSeg)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic mmsc_pkg::seg_class_e classify_desc(logic [31:0] mem_type,
                                                         logic [63:0] attr);
    case (mem_type)
      mmsc_pkg::MT_LOADER_CODE, mmsc_pkg::MT_LOADER_DATA, mmsc_pkg::MT_BS_CODE,
      mmsc_pkg::MT_BS_DATA, mmsc_pkg::MT_CONVENTIONAL:
        return attr[mmsc_pkg::AttrWbBit] ? mmsc_pkg::CLS_MEMORY : mmsc_pkg::CLS_RESERVED;
      mmsc_pkg::MT_ACPI_RECLAIM: return mmsc_pkg::CLS_ACPI;
      mmsc_pkg::MT_ACPI_NVS:     return mmsc_pkg::CLS_NVS;
      mmsc_pkg::MT_PERSISTENT:   return mmsc_pkg::CLS_PMEM;
      default:                   return mmsc_pkg::CLS_RESERVED;
    endcase
  endfunction

  function automatic int idle_pct(bit sender);
    int phase;
    phase = (n_accepted * 3) / n_total;
    if (phase == 0) return sender ? 11 : 74;
    if (phase == 1) return sender ? 74 : 11;
    return 0;
  endfunction

  task automatic clear_coalescer();
    pend_start = '0;
    pend_end   = '0;
    pend_class = mmsc_pkg::CLS_MEMORY;
    pend_valid = 1'b0;
    seg_count  = 0;
    limit_hit  = 1'b0;
  endtask

  task automatic open_segment(desc_item_t d, mmsc_pkg::seg_class_e c, logic [63:0] sz);
    pend_start = d.addr;
    pend_end   = d.addr + sz;
    pend_class = c;
    pend_valid = 1'b1;
  endtask

  task automatic coalesce_desc(desc_item_t d);
    seg_result_t          r;
    logic [63:0]          sz;
    mmsc_pkg::seg_class_e c;
    r = '{seg_valid: 1'b0, addr: '0, size: '0, cls: mmsc_pkg::CLS_MEMORY, index: '0,
          final_res: 1'b0, overflow: 1'b0};
    if (d.kind == mmsc_pkg::KIND_FINISH) begin
      r.final_res = 1'b1;
      if (pend_valid && !limit_hit && seg_count < MaxSeg) begin
        r.seg_valid = 1'b1;
        r.addr      = pend_start;
        r.size      = pend_end - pend_start;
        r.cls       = pend_class;
        r.index     = seg_count[4:0];
      end else if (limit_hit) begin
        r.overflow = 1'b1;
      end
      seg_expect_q.push_back(r);
      clear_coalescer();
    end else if (!limit_hit) begin
      sz = {d.pages, 12'b0};
      c  = classify_desc(d.mem_type, d.attr);
      if (!pend_valid) begin
        open_segment(d, c, sz);
      end else if (c == pend_class && pend_end == d.addr) begin
        pend_end = d.addr + sz;
      end else begin
        r.seg_valid = 1'b1;
        r.addr      = pend_start;
        r.size      = pend_end - pend_start;
        r.cls       = pend_class;
        r.index     = seg_count[4:0];
        seg_expect_q.push_back(r);
        seg_count++;
        // table full: the breaking descriptor is dropped too
        if (seg_count >= MaxSeg) begin
          limit_hit  = 1'b1;
          pend_valid = 1'b0;
        end else begin
          open_segment(d, c, sz);
        end
      end
    end
  endtask

  task automatic check_field(string name, logic [63:0] expd, logic [63:0] act);
    if (expd !== act) begin
      $error("%s: expected %0h, actual %0h", name, expd, act);
      n_errors++;
    end
  endtask

  task automatic push_item(mmsc_pkg::item_kind_e k, logic [63:0] a, logic [51:0] p,
                           logic [31:0] t, logic [63:0] at);
    desc_item_t d;
    d.kind = k;
    d.addr = a;
    d.pages = p;
    d.mem_type = t;
    d.attr = at;
    desc_q.push_back(d);
  endtask

  // driver: a new beat is loaded only when the slot is free
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        coalesce_desc(cur_desc);
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (desc_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b1) &&
            !((n_accepted == HoldA || n_accepted == HoldB) && seg_expect_q.size() != 0)) begin
          cur_desc = desc_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0, cur_desc.attr, cur_desc.mem_type, cur_desc.pages,
                            cur_desc.addr};
          s_axis_tuser  <= cur_desc.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  // monitor
  always @(posedge clk_i) begin : seg_monitor
    seg_result_t expd;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (seg_expect_q.size() == 0) begin
        $error("result beat with no segment expected: tdata %0h tuser %0h",
               m_axis_tdata, m_axis_tuser);
        n_errors++;
      end else begin
        expd = seg_expect_q.pop_front();
        check_field("seg_valid", expd.seg_valid, m_axis_tuser[0]);
        check_field("final_res", expd.final_res, m_axis_tuser[1]);
        check_field("overflow",  expd.overflow,  m_axis_tuser[2]);
        check_field("seg_addr",  expd.addr,      m_axis_tdata[63:0]);
        check_field("seg_size",  expd.size,      m_axis_tdata[127:64]);
        check_field("seg_class", expd.cls,       m_axis_tdata[130:128]);
        check_field("seg_index", expd.index,     m_axis_tdata[135:131]);
      end
    end
  end

  initial begin : stim
    logic [31:0] named_types[8];
    logic [63:0] next_addr, r64;
    logic [31:0] cur_type;
    logic [63:0] cur_attr;
    int          sel, len, contig_pct, k;
    bit          long_map;

    named_types = '{mmsc_pkg::MT_LOADER_CODE, mmsc_pkg::MT_LOADER_DATA,
                    mmsc_pkg::MT_BS_CODE, mmsc_pkg::MT_BS_DATA,
                    mmsc_pkg::MT_CONVENTIONAL, mmsc_pkg::MT_ACPI_RECLAIM,
                    mmsc_pkg::MT_ACPI_NVS, mmsc_pkg::MT_PERSISTENT};
    clear_coalescer();

    // directed: empty map, every class, merge vs break, wrapping end
    push_item(mmsc_pkg::KIND_FINISH, '0, '0, '0, '0);
    push_item(mmsc_pkg::KIND_DESC, 64'h0, 52'h10, mmsc_pkg::MT_CONVENTIONAL, 64'h8);
    push_item(mmsc_pkg::KIND_DESC, 64'h1_0000, 52'h1, mmsc_pkg::MT_LOADER_CODE, '1);
    push_item(mmsc_pkg::KIND_DESC, 64'h1_1000, 52'h2, mmsc_pkg::MT_LOADER_DATA, '0);
    push_item(mmsc_pkg::KIND_DESC, 64'h1_3000, 52'h4, mmsc_pkg::MT_BS_CODE, ~64'h8);
    push_item(mmsc_pkg::KIND_DESC, 64'h10_0000, 52'h3, mmsc_pkg::MT_BS_DATA, 64'h8);
    push_item(mmsc_pkg::KIND_DESC, 64'h10_3000, 52'h5, mmsc_pkg::MT_ACPI_RECLAIM, '0);
    push_item(mmsc_pkg::KIND_DESC, 64'h10_8000, 52'h1, mmsc_pkg::MT_ACPI_NVS, '1);
    push_item(mmsc_pkg::KIND_DESC, 64'h10_9000, 52'h7, mmsc_pkg::MT_PERSISTENT, '0);
    push_item(mmsc_pkg::KIND_DESC, 64'h11_0000, 52'h1, '0, 64'h8);
    push_item(mmsc_pkg::KIND_DESC, 64'h11_1000, 52'h2, '1, 64'h8);
    push_item(mmsc_pkg::KIND_DESC, 64'h5555_0000, 52'h0, mmsc_pkg::MT_PERSISTENT + 32'd1,
              '0);
    push_item(mmsc_pkg::KIND_FINISH, '1, '1, '1, '1);
    push_item(mmsc_pkg::KIND_DESC, 64'hFFFF_FFFF_FFFF_F000, '1, mmsc_pkg::MT_CONVENTIONAL,
              64'h8);
    push_item(mmsc_pkg::KIND_DESC, 64'hFFFF_FFFF_FFFF_E000, '1, mmsc_pkg::MT_BS_CODE, 64'h8);
    push_item(mmsc_pkg::KIND_DESC, 64'h0, 52'h0, mmsc_pkg::MT_PERSISTENT, '0);
    push_item(mmsc_pkg::KIND_FINISH, '0, '0, '0, '0);
    push_item(mmsc_pkg::KIND_DESC, '1, '0, mmsc_pkg::MT_ACPI_RECLAIM, '1);
    push_item(mmsc_pkg::KIND_FINISH, '0, '0, '0, '0);

    // random maps; long ones mostly break so the segment table fills up
    while (desc_q.size() < 835) begin
      sel = $urandom_range(99);
      long_map = (sel < 25);
      if (long_map) len = $urandom_range(36, 45);
      else if (sel < 40) len = $urandom_range(0, 3);
      else len = $urandom_range(4, 20);
      contig_pct = long_map ? 5 : 65;
      next_addr = {$urandom(), $urandom()};
      cur_type = mmsc_pkg::MT_CONVENTIONAL;
      cur_attr = '0;
      for (k = 0; k < len; k++) begin
        r64 = {$urandom(), $urandom()};
        if ($urandom_range(99) >= contig_pct) begin
          next_addr = ($urandom_range(1) != 0) ? r64 : {36'b0, r64[27:0]};
        end
        if (k == 0 || $urandom_range(99) >= 60) begin
          sel = $urandom_range(19);
          if (sel < 8) cur_type = named_types[sel];
          else if (sel < 16) cur_type = $urandom_range(0, 20);
          else cur_type = $urandom();
          cur_attr = {$urandom(), $urandom()};
        end
        r64 = {$urandom(), $urandom()};
        if ($urandom_range(9) != 0) r64 = 64'($urandom_range(0, 64));
        push_item(mmsc_pkg::KIND_DESC, next_addr, r64[51:0], cur_type, cur_attr);
        next_addr = next_addr + {r64[51:0], 12'b0};
      end
      r64 = {$urandom(), $urandom()};
      push_item(mmsc_pkg::KIND_FINISH, {$urandom(), $urandom()}, r64[51:0],
                $urandom(), {$urandom(), $urandom()});
    end
    n_total = desc_q.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (desc_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    for (k = 0; k < 5000 && seg_expect_q.size() != 0; k++) @(posedge clk_i);
    if (seg_expect_q.size() != 0) begin
      $error("%0d expected segment beats never arrived", seg_expect_q.size());
      n_errors++;
    end
    repeat (10) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
